FILE: hdl/ssrs_pkg.sv
`default_nettype none
package ssrs_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CAP_W  = 28;
  // signed width holding every slot, return point and branch distance
  localparam int unsigned DIST_W = 51;

  localparam logic [WORD_W-1:0] SVC_ZERO     = 32'hD400_0001;
  localparam logic [WORD_W-1:0] B_OP         = 32'h1400_0000;
  localparam logic [WORD_W-1:0] MOVZ_RD_MASK = 32'hFFE0_001F;
  localparam logic [WORD_W-1:0] MOVZ_X8      = 32'hD280_0008;
  localparam logic [15:0]       NR_SIGRETURN = 16'd139;
  localparam logic [WORD_W-1:0] IMM26_MASK   = 32'h03FF_FFFF;
  localparam logic [WORD_W-1:0] GRP_A_MASK   = 32'h7F80_0000;
  localparam logic [WORD_W-1:0] GRP_B_MASK   = 32'h7FC0_0000;
  localparam logic [WORD_W-1:0] GRP_C_MASK   = 32'h3B00_0000;
  localparam logic [WORD_W-1:0] MOVZ_W_OP    = 32'h5280_0000;
  localparam logic [WORD_W-1:0] MOVK_W_OP    = 32'h7280_0000;
  localparam logic [WORD_W-1:0] ADD_IMM_OP   = 32'h1100_0000;
  localparam logic [WORD_W-1:0] SUB_IMM_OP   = 32'h5100_0000;
  localparam logic [WORD_W-1:0] AND_REG_OP   = 32'h0A00_0000;
  localparam logic [WORD_W-1:0] ORR_REG_OP   = 32'h2A00_0000;
  localparam logic [WORD_W-1:0] EOR_REG_OP   = 32'h4A00_0000;
  localparam logic [WORD_W-1:0] LDR_UIMM_OP  = 32'h3900_0000;
  localparam logic [WORD_W-1:0] LDR_LIT_OP   = 32'h1800_0000;
  localparam logic [4:0]        REG_X8       = 5'd8;

  // configuration register indexes
  localparam logic [1:0] CFG_POOL_BASE      = 2'd0;
  localparam logic [1:0] CFG_POOL_CAPACITY  = 2'd1;
  localparam logic [1:0] CFG_VERIFY_CONTEXT = 2'd2;

  // status codes
  localparam logic [2:0] ST_OUTSIDE    = 3'd0;
  localparam logic [2:0] ST_NOT_SVC    = 3'd1;
  localparam logic [2:0] ST_SIGRETURN  = 3'd2;
  localparam logic [2:0] ST_NO_X8      = 3'd3;
  localparam logic [2:0] ST_UNREACH    = 3'd4;
  localparam logic [2:0] ST_POOL_FULL  = 3'd5;
  localparam logic [2:0] ST_RET_UNREACH = 3'd6;
  localparam logic [2:0] ST_PATCHED    = 3'd7;

  // what one history cell remembers about its word
  typedef struct packed {
    logic valid;
    logic x8;
    logic sigret;
  } hist_t;

  function automatic logic sets_x8(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] ga;
    logic [WORD_W-1:0] gb;
    logic [WORD_W-1:0] gc;
    ga = w & GRP_A_MASK;
    gb = w & GRP_B_MASK;
    gc = w & GRP_C_MASK;
    return (w[4:0] == REG_X8) &&
           (ga == MOVZ_W_OP || ga == MOVK_W_OP || ga == ADD_IMM_OP || ga == SUB_IMM_OP ||
            gb == AND_REG_OP || gb == ORR_REG_OP || gb == EOR_REG_OP ||
            gc == LDR_UIMM_OP || gc == LDR_LIT_OP);
  endfunction

  function automatic logic is_sigret(input logic [WORD_W-1:0] w);
    return ((w & MOVZ_RD_MASK) == MOVZ_X8) && (w[20:5] == NR_SIGRETURN);
  endfunction

  // -2^27 <= d < 2^27 and word aligned
  function automatic logic in_reach(input logic signed [DIST_W-1:0] d);
    return (d[1:0] == 2'b00) &&
           ((d[DIST_W-1:27] == '0) || (d[DIST_W-1:27] == '1));
  endfunction

  function automatic logic [WORD_W-1:0] branch_word(input logic signed [DIST_W-1:0] d);
    return B_OP | ({6'd0, d[27:2]} & IMM26_MASK);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/ssrs_in_if.sv
`default_nettype none
interface ssrs_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] word_addr;
  logic [31:0] code_word;
  logic        in_range;
  logic        mapping_start;

  modport source (output valid, word_addr, code_word, in_range, mapping_start, input ready);
  modport sink (input valid, word_addr, code_word, in_range, mapping_start, output ready);
endinterface
`default_nettype wire

FILE: hdl/ssrs_out_if.sv
`default_nettype none
interface ssrs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] new_word;
  logic [47:0] slot_addr;
  logic [31:0] back_word;

  modport source (output valid, status, new_word, slot_addr, back_word, input ready);
  modport sink (input valid, status, new_word, slot_addr, back_word, output ready);
endinterface
`default_nettype wire

FILE: hdl/ssrs_cell.sv
`default_nettype none
module ssrs_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_i,
  input  wire ssrs_pkg::hist_t prev_i,
  output ssrs_pkg::hist_t    cur_o
);

  ssrs_pkg::hist_t cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (shift_i) begin
      cell_q <= prev_i;
    end
  end

  assign cur_o = cell_q;

endmodule
`default_nettype wire

FILE: hdl/syscall_site_rewrite_scanner.sv
`default_nettype none
// syscall site rewrite scanner: one result word per code word, in order
// the result is registered as the code word is taken
// throughput: one word per cycle; ready stays high while the result register is empty
//   or being drained, so the history cell row and pool counters never stall a stream
// reset: history cells invalid, pool use zero, pool base and capacity zero, verify on
module syscall_site_rewrite_scanner #(
  parameter int unsigned TRAMP_BYTES    = 64,
  parameter int unsigned BACK_OFFSET    = 56,
  parameter int unsigned LOOKBACK_WORDS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_data_i,
  ssrs_in_if.sink          in_i,
  ssrs_out_if.source       out_o
);

  localparam int unsigned AW = ssrs_pkg::DIST_W;
  localparam int unsigned CW = ssrs_pkg::CAP_W;
  // return point minus the site's next word, folded into one offset
  localparam logic signed [AW-1:0] BACK_ADJ =
    AW'($signed(BACK_OFFSET) - 4);
  localparam logic signed [AW-1:0] TRAMP_STEP = AW'(TRAMP_BYTES);

  // config and pool state
  logic [CW-1:0]          pool_cap_q;
  logic                   verify_q;
  logic [CW-1:0]          pool_used_q;
  // slot_q tracks pool_base + pool_used, back_q tracks slot + BACK_OFFSET - 4
  logic signed [AW-1:0]   slot_q;
  logic signed [AW-1:0]   back_q;

  // output register
  logic                   out_valid_q;
  logic [2:0]             status_q;
  logic [31:0]            new_word_q;
  logic [47:0]            slot_addr_q;
  logic [31:0]            back_word_q;

  logic                   take;
  logic                   start;
  logic                   patch;

  // history cell row, cell 0 is the most recent word
  ssrs_pkg::hist_t        cell_in  [LOOKBACK_WORDS];
  ssrs_pkg::hist_t        cell_out [LOOKBACK_WORDS];
  logic [LOOKBACK_WORDS-1:0] x8_hits;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign take       = in_i.valid && in_i.ready;
  assign start      = in_i.mapping_start;

  // new word enters cell 0 always valid; older words lose validity on mapping start
  always_comb begin
    cell_in[0].valid  = 1'b1;
    cell_in[0].x8     = ssrs_pkg::sets_x8(in_i.code_word);
    cell_in[0].sigret = ssrs_pkg::is_sigret(in_i.code_word);
    for (int k = 1; k < LOOKBACK_WORDS; k++) begin
      cell_in[k]       = cell_out[k-1];
      cell_in[k].valid = cell_out[k-1].valid && !start;
    end
  end

  for (genvar g = 0; g < LOOKBACK_WORDS; g++) begin : g_cell
    ssrs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (take),
      .prev_i  (cell_in[g]),
      .cur_o   (cell_out[g])
    );
    assign x8_hits[g] = cell_out[g].valid && cell_out[g].x8;
  end

  // site checks against the history as it stood before this word
  logic                   x8_seen;
  logic                   sig_prev;
  logic signed [AW-1:0]   addr_s;
  logic signed [AW-1:0]   dist_fwd;
  logic signed [AW-1:0]   dist_back;
  logic                   fwd_ok;
  logic                   back_ok;
  logic [CW:0]            used_sum;
  logic                   pool_full;
  logic [2:0]             status_d;

  assign x8_seen   = (|x8_hits) && !start;
  assign sig_prev  = cell_out[0].valid && cell_out[0].sigret && !start;
  assign addr_s    = $signed({{(AW-48){1'b0}}, in_i.word_addr});
  assign dist_fwd  = slot_q - addr_s;
  assign dist_back = addr_s - back_q;
  assign fwd_ok    = ssrs_pkg::in_reach(dist_fwd);
  assign back_ok   = ssrs_pkg::in_reach(dist_back);
  assign used_sum  = {1'b0, pool_used_q} + (CW+1)'(TRAMP_BYTES);
  assign pool_full = used_sum > {1'b0, pool_cap_q};

  // checks in priority order
  always_comb begin
    if (!in_i.in_range) begin
      status_d = ssrs_pkg::ST_OUTSIDE;
    end else if (in_i.code_word != ssrs_pkg::SVC_ZERO) begin
      status_d = ssrs_pkg::ST_NOT_SVC;
    end else if (sig_prev) begin
      status_d = ssrs_pkg::ST_SIGRETURN;
    end else if (verify_q && !x8_seen) begin
      status_d = ssrs_pkg::ST_NO_X8;
    end else if (!fwd_ok) begin
      status_d = ssrs_pkg::ST_UNREACH;
    end else if (pool_full) begin
      status_d = ssrs_pkg::ST_POOL_FULL;
    end else if (!back_ok) begin
      status_d = ssrs_pkg::ST_RET_UNREACH;
    end else begin
      status_d = ssrs_pkg::ST_PATCHED;
    end
  end

  assign patch = take && (status_d == ssrs_pkg::ST_PATCHED);

  // config registers and pool tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_cap_q  <= '0;
      verify_q    <= 1'b1;
      pool_used_q <= '0;
      slot_q      <= '0;
      back_q      <= BACK_ADJ;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ssrs_pkg::CFG_POOL_BASE: begin
          slot_q <= $signed({{(AW-48){1'b0}}, cfg_data_i}) +
                    $signed({{(AW-CW){1'b0}}, pool_used_q});
          back_q <= $signed({{(AW-48){1'b0}}, cfg_data_i}) +
                    $signed({{(AW-CW){1'b0}}, pool_used_q}) + BACK_ADJ;
        end
        ssrs_pkg::CFG_POOL_CAPACITY:  pool_cap_q <= cfg_data_i[CW-1:0];
        ssrs_pkg::CFG_VERIFY_CONTEXT: verify_q   <= cfg_data_i[0];
        default: ;
      endcase
    end else if (patch) begin
      pool_used_q <= used_sum[CW-1:0];
      slot_q      <= slot_q + TRAMP_STEP;
      back_q      <= back_q + TRAMP_STEP;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q    <= status_d;
      new_word_q  <= patch ? ssrs_pkg::branch_word(dist_fwd) : '0;
      slot_addr_q <= patch ? slot_q[47:0] : '0;
      back_word_q <= patch ? ssrs_pkg::branch_word(dist_back) : '0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = status_q;
  assign out_o.new_word  = new_word_q;
  assign out_o.slot_addr = slot_addr_q;
  assign out_o.back_word = back_word_q;

endmodule
`default_nettype wire
